@@ src/ltdith_pkg.sv @@
// Shared constants, types and build-time tables of the LED temporal dither block.
package ltdith_pkg;

   localparam int SLOTS        = 64;
   localparam int LEDS         = 4096;
   localparam int TABLE_CAP    = 254;
   localparam int GAMMA_TENTHS = 22;
   localparam int STORE_DEPTH  = 3 * LEDS;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);

   localparam int COLOUR_W = 8;
   localparam int IDX_W    = 14;
   localparam int TONE_W   = 17;
   localparam int PROD_W   = TONE_W + 8;
   localparam int QUOT_W   = 23;
   localparam int FRAC_W   = 16;
   localparam int SLOT_W   = 7;
   localparam int SEND_W   = 8;
   localparam int WIDE_W   = 400;

   localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
   localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;
   localparam logic [31:0] DIV_BY     = 32'd255;

   localparam logic [FRAC_W:0]  Q_ONE      = 17'd65536;
   localparam logic [FRAC_W:0]  HALF_FRAC  = 17'd32768;
   localparam logic [QUOT_W:0]  ROUND_HALF = 24'd32768;
   localparam logic [IDX_W-1:0] INDEX_LAST = IDX_W'(STORE_DEPTH - 1);

   localparam logic [7:0]        CAP_RESET    = 8'd254;
   localparam logic              DITHER_RESET = 1'b1;
   localparam logic [FRAC_W-1:0] THRESH_RESET = 16'd13107;

   typedef enum logic [1:0] {
      REG_CAP    = 2'd0,
      REG_DITHER = 2'd1,
      REG_THRESH = 2'd2
   } reg_index_type;

   typedef logic [TONE_W-1:0] tone_rom_type [256];
   typedef logic [SEND_W-1:0] send_rom_type [SLOTS + 1];

   // Wanted slots of one request, with its accumulator index.
   typedef struct packed {
      logic              zero;
      logic [IDX_W-1:0]  index;
      logic [QUOT_W-1:0] want;
   } want_type;

   typedef struct packed {
      logic              dither;
      logic [FRAC_W-1:0] thresh;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [FRAC_W-1:0] data;
   } frac_wr_type;

   // Largest Y with (Y/65536)^10 <= (v/255)^GAMMA_TENTHS, in wide integers.
   function automatic tone_rom_type build_tone();
      tone_rom_type     rom;
      logic [WIDE_W-1:0] den;
      logic [WIDE_W-1:0] rhs;
      logic [WIDE_W-1:0] lhs;
      int unsigned       lo;
      int unsigned       hi;
      int unsigned       mid;
      den = WIDE_W'(1);
      for (int k = 0; k < GAMMA_TENTHS; k++) begin
         den = den * WIDE_W'(255);
      end
      for (int v = 0; v < 256; v++) begin
         rhs = WIDE_W'(1) << 160;
         for (int k = 0; k < GAMMA_TENTHS; k++) begin
            rhs = rhs * WIDE_W'(v);
         end
         lo = 0;
         hi = 65536;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = WIDE_W'(1);
            for (int k = 0; k < 10; k++) begin
               lhs = lhs * WIDE_W'(mid);
            end
            lhs = lhs * den;
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         rom[v] = TONE_W'(lo);
      end
      return rom;
   endfunction

   function automatic int slots_of(int unsigned tone);
      int unsigned byte_val;
      int unsigned n;
      byte_val = (tone * TABLE_CAP) >> 16;
      if (byte_val > 255) begin
         byte_val = 255;
      end
      n = (byte_val * SLOTS + 127) / 255;
      if (n > SLOTS) begin
         n = SLOTS;
      end
      return int'(n);
   endfunction

   function automatic send_rom_type build_send(tone_rom_type tone);
      send_rom_type rom;
      int           first [SLOTS + 1];
      int           last  [SLOTS + 1];
      int           n;
      for (int i = 0; i <= SLOTS; i++) begin
         first[i] = -1;
         last[i]  = -1;
      end
      for (int v = 0; v < 256; v++) begin
         n = slots_of(int'(tone[v]));
         if (first[n] < 0) begin
            first[n] = v;
         end
         last[n] = v;
      end
      for (int i = 0; i <= SLOTS; i++) begin
         if (first[i] >= 0) begin
            rom[i] = SEND_W'((first[i] + last[i]) / 2);
         end else if (i > 0) begin
            rom[i] = rom[i - 1];
         end else begin
            rom[i] = '0;
         end
      end
      rom[0] = '0;
      return rom;
   endfunction

   function automatic logic [SLOT_W-1:0] build_top(tone_rom_type tone);
      int top;
      int n;
      top = 0;
      for (int v = 0; v < 256; v++) begin
         n = slots_of(int'(tone[v]));
         if (n > top) begin
            top = n;
         end
      end
      return SLOT_W'(top);
   endfunction

   localparam tone_rom_type       TONE_ROM = build_tone();
   localparam send_rom_type       SEND_ROM = build_send(TONE_ROM);
   localparam logic [SLOT_W-1:0]  TOP_SLOT = build_top(TONE_ROM);

endpackage

@@ src/ltdith_scale.sv @@
// Four-stage pipeline: gamma lookup, brightness product, divide by 255 in two steps.
module ltdith_scale import ltdith_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [COLOUR_W-1:0] in_colour,
   input  logic [IDX_W-1:0]    in_index,
   input  logic [7:0]          cap,
   output logic                out_valid,
   input  logic                out_ready,
   output want_type            out_want,
   output logic [IDX_W-1:0]    next_index
);

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic              s1_load, s2_load, s3_load, s4_load;
   logic [TONE_W-1:0] s1_tone_ff;
   logic              s1_zero_ff, s2_zero_ff, s3_zero_ff;
   logic [IDX_W-1:0]  s1_index_ff, s2_index_ff, s3_index_ff;
   logic [PROD_W-1:0] s2_prod_ff, s3_prod_ff;
   logic [QUOT_W-1:0] s3_quot_ff;
   want_type          s4_want_ff;

   logic [30:0]       s2_scaled;
   logic [31:0]       s2_series;
   logic [30:0]       s3_scaled;
   logic [31:0]       s3_rem;
   want_type          s4_want_in;

   // A stage loads when it is empty or its content moves on.
   assign s4_load  = !s4_valid_ff || out_ready;
   assign s3_load  = !s3_valid_ff || s4_load;
   assign s2_load  = !s2_valid_ff || s3_load;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign in_ready = s1_load;

   // y/255 from y/256 * (1 + 1/256 + ...); low by at most one.
   always_comb begin
      s2_scaled = 31'(s2_prod_ff) * 31'(SLOTS);
      s2_series = 32'(s2_scaled) + 32'(s2_scaled >> 8) + 32'(s2_scaled >> 16)
                + 32'(s2_scaled >> 24);
   end

   // One compare and subtract fixes the estimate.
   always_comb begin
      s3_scaled        = 31'(s3_prod_ff) * 31'(SLOTS);
      s3_rem           = 32'(s3_scaled) - 32'(s3_quot_ff) * DIV_BY;
      s4_want_in.zero  = s3_zero_ff;
      s4_want_in.index = s3_index_ff;
      s4_want_in.want  = s3_quot_ff + QUOT_W'(s3_rem >= DIV_BY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff <= in_valid;
         if (s2_load) s2_valid_ff <= s1_valid_ff;
         if (s3_load) s3_valid_ff <= s2_valid_ff;
         if (s4_load) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_tone_ff  <= TONE_ROM[in_colour];
         s1_zero_ff  <= (in_colour == '0);
         s1_index_ff <= in_index;
      end
      if (s2_load) begin
         s2_prod_ff  <= PROD_W'(s1_tone_ff) * PROD_W'(cap);
         s2_zero_ff  <= s1_zero_ff;
         s2_index_ff <= s1_index_ff;
      end
      if (s3_load) begin
         s3_quot_ff  <= QUOT_W'(s2_series >> 8);
         s3_prod_ff  <= s2_prod_ff;
         s3_zero_ff  <= s2_zero_ff;
         s3_index_ff <= s2_index_ff;
      end
      if (s4_load) begin
         s4_want_ff <= s4_want_in;
      end
   end

   assign out_valid  = s4_valid_ff;
   assign out_want   = s4_want_ff;
   assign next_index = s4_load ? s3_index_ff : s4_want_ff.index;

endmodule

@@ src/ltdith_frac_ram.sv @@
// Fraction accumulator memory with its hash-seeded clearing pass after reset.
module ltdith_frac_ram import ltdith_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [FRAC_W-1:0] rd_data,
   input  frac_wr_type       wr,
   output logic              busy
);

   logic [FRAC_W-1:0] store_ff [STORE_DEPTH];
   logic [FRAC_W-1:0] rd_data_ff;

   logic              clr_run_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic              h1_valid_ff, h2_valid_ff;
   logic [ADDR_W-1:0] h1_addr_ff, h2_addr_ff;
   logic [31:0]       h1_mul_ff, h2_mul_ff;
   logic [31:0]       seed, mix0, mix1, mix2;

   always_comb begin
      seed = 32'(clr_cnt_ff) + 32'd1;
      mix0 = seed ^ (seed >> 16);
      mix1 = h1_mul_ff ^ (h1_mul_ff >> 15);
      mix2 = h2_mul_ff ^ (h2_mul_ff >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_run_ff  <= 1'b1;
         clr_cnt_ff  <= '0;
         h1_valid_ff <= 1'b0;
         h2_valid_ff <= 1'b0;
      end else begin
         h1_valid_ff <= clr_run_ff;
         h2_valid_ff <= h1_valid_ff;
         if (clr_run_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(STORE_DEPTH - 1)) clr_run_ff <= 1'b0;
         end
      end
   end

   // Hash pipeline: one multiply per stage.
   always_ff @(posedge clock) begin
      h1_addr_ff <= clr_cnt_ff;
      h1_mul_ff  <= mix0 * HASH_MUL_A;
      h2_addr_ff <= h1_addr_ff;
      h2_mul_ff  <= mix1 * HASH_MUL_B;
   end

   always_ff @(posedge clock) begin
      if (h2_valid_ff) begin
         store_ff[h2_addr_ff] <= mix2[31:16];
      end else if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_run_ff | h1_valid_ff | h2_valid_ff;

endmodule

@@ src/ltdith_decide.sv @@
// Slot decision, accumulator update and output register.
module ltdith_decide import ltdith_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  want_type          in_want,
   input  logic [IDX_W-1:0]  next_index,
   input  cfg_type           cfg,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [FRAC_W-1:0] rd_data,
   output frac_wr_type       wr,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [SEND_W-1:0] out_send,
   output logic [SLOT_W-1:0] out_slots
);

   logic              out_valid_ff;
   logic [SEND_W-1:0] send_ff;
   logic [SLOT_W-1:0] slots_ff;
   logic              byp_valid_ff;
   logic [FRAC_W-1:0] byp_data_ff;

   logic [FRAC_W:0]   lo_frac, hi_frac, frac_ext, acc_sum;
   logic [FRAC_W-1:0] acc_word;
   logic [SLOT_W-1:0] whole, count;
   logic [QUOT_W:0]   rounded;
   logic              in_range, acc_en;

   assign in_ready = !out_valid_ff || out_ready;
   assign rd_addr  = (next_index <= INDEX_LAST) ? ADDR_W'(next_index) : '0;
   // Take the word just written when the read hit the same entry.
   assign acc_word = byp_valid_ff ? byp_data_ff : rd_data;

   always_comb begin
      lo_frac  = ({1'b0, cfg.thresh} > HALF_FRAC) ? HALF_FRAC : {1'b0, cfg.thresh};
      hi_frac  = Q_ONE - lo_frac;
      frac_ext = {1'b0, in_want.want[FRAC_W-1:0]};
      whole    = in_want.want[QUOT_W-1:FRAC_W];
      rounded  = {1'b0, in_want.want} + ROUND_HALF;
      acc_sum  = {1'b0, acc_word} + frac_ext;
      in_range = (in_want.index <= INDEX_LAST);
      acc_en   = 1'b0;
      priority if (in_want.zero) begin
         count = '0;
      end else if (!cfg.dither) begin
         count = SLOT_W'(rounded >> FRAC_W);
      end else if (frac_ext > hi_frac) begin
         count = whole + 1'b1;
      end else if (frac_ext >= lo_frac && in_range) begin
         count  = whole + SLOT_W'(acc_sum[FRAC_W]);
         acc_en = 1'b1;
      end else begin
         count = whole;
      end
      if (count > TOP_SLOT) count = TOP_SLOT;
   end

   always_comb begin
      wr.en   = acc_en && in_valid && in_ready;
      wr.addr = ADDR_W'(in_want.index);
      wr.data = acc_sum[FRAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         if (in_ready) out_valid_ff <= in_valid;
         byp_valid_ff <= wr.en && (wr.addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= wr.data;
      if (in_ready) begin
         send_ff  <= SEND_ROM[count];
         slots_ff <= count;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_send  = send_ff;
   assign out_slots = slots_ff;

endmodule

@@ src/led_temporal_dither.sv @@
// Top level of the LED temporal dither block: register port, pipeline and accumulator store.
//
//   channel   direction  payload (low bit first)                 handshake
//   req_*     in         colour_value[7:0], led_colour_index[21:8] tvalid/tready
//   rsp_*     out        send_byte[7:0], slot_count[14:8]          tvalid/tready
//   csr_*     in/out     brightness_cap, dither_on, min_fraction   APB, pready high
//
// One request per clock while the output is not stalled and no clearing pass runs; a result
// moves through the scale stages to the output register. The divide by 255 is split
// over two stages and the accumulator read, add and write-back sit in the last stage
// before the output register. After reset a clearing pass seeds all 12288 accumulators
// from a hash, one entry a cycle; req_tready stays low meanwhile.
// A stalled output holds its result; empty stages further up still fill.
module led_temporal_dither import ltdith_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request: [7:0] colour_value, [21:8] led_colour_index, [23:22] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // response: [7:0] send_byte, [14:8] slot_count, [15] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]        cap_ff;
   logic              dither_ff;
   logic [FRAC_W-1:0] thresh_ff;
   logic              csr_write;
   reg_index_type     csr_index;

   logic              ram_busy;
   logic              scale_in_ready;
   logic              want_valid, want_ready;
   want_type          want;
   logic [IDX_W-1:0]  next_index;
   logic [ADDR_W-1:0] rd_addr;
   logic [FRAC_W-1:0] rd_data;
   frac_wr_type       acc_wr;
   cfg_type           cfg;
   logic [SEND_W-1:0] send_byte;
   logic [SLOT_W-1:0] slot_count;

   // Register port: write on the access cycle, read straight from the registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         dither_ff <= DITHER_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CAP:    cap_ff    <= csr_pwdata[7:0];
            REG_DITHER: dither_ff <= csr_pwdata[0];
            REG_THRESH: thresh_ff <= csr_pwdata[FRAC_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CAP:    csr_prdata = {24'd0, cap_ff};
         REG_DITHER: csr_prdata = {31'd0, dither_ff};
         REG_THRESH: csr_prdata = {16'd0, thresh_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.dither = dither_ff;
   assign cfg.thresh = thresh_ff;

   // Hold off requests until the accumulators are seeded.
   assign req_tready = scale_in_ready && !ram_busy;

   ltdith_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid && !ram_busy),
      .in_ready   (scale_in_ready),
      .in_colour  (req_tdata[7:0]),
      .in_index   (req_tdata[21:8]),
      .cap        (cap_ff),
      .out_valid  (want_valid),
      .out_ready  (want_ready),
      .out_want   (want),
      .next_index (next_index)
   );

   ltdith_frac_ram u_frac_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (acc_wr),
      .busy    (ram_busy)
   );

   ltdith_decide u_decide (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (want_valid),
      .in_ready   (want_ready),
      .in_want    (want),
      .next_index (next_index),
      .cfg        (cfg),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr         (acc_wr),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_send   (send_byte),
      .out_slots  (slot_count)
   );

   assign rsp_tdata = {1'b0, slot_count, send_byte};

   // The slot count never passes the largest count the send table reaches.
   a_slot_top: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:8] <= TOP_SLOT)
      else $error("slot count above table top");

   // Accumulator updates never collide with the clearing pass.
   a_wr_idle: assert property (@(posedge clock) disable iff (reset)
      acc_wr.en |-> !ram_busy)
      else $error("accumulator write during clearing pass");

   // An accumulator update always goes with a result loaded into the output.
   a_wr_out: assert property (@(posedge clock) disable iff (reset)
      acc_wr.en |=> rsp_tvalid)
      else $error("accumulator written without a result");

endmodule
